[src/ils_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Command and status codes, field widths and the control and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned CMD_W       = 4;
  localparam int unsigned INDEX_W     = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_REMOVE     = 4'd4,
    CMD_INSERT     = 4'd5,
    CMD_SET        = 4'd6,
    CMD_READ       = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_INDEX = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    LEN_KEEP = 2'd0,
    LEN_INC  = 2'd1,
    LEN_DEC  = 2'd2,
    LEN_CLR  = 2'd3
  } len_op_e;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_NEG1 = 2'd1,
    RD_MEM  = 2'd2
  } rd_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DRAIN,
    S_WRITE,
    S_FINISH,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic     capture;    // register the incoming beat
    logic     walk_init;  // load the walk pointer
    logic     walk_open;  // walk direction: open a gap (1) or close one (0)
    logic     walk_step;  // move one element
    logic     drain;      // write the last element read by the walk
    logic     wr_value;   // write the command's value
    logic     wr_tail;    // value goes to the tail instead of the position
    logic     fetch;      // read the element at the position
    len_op_e  len_op;
    logic     res_load;
    status_e  res_status;
    rd_kind_e res_rd;
    logic     out_load;
  } dp_ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             idx_ok;
    logic             open_none;
    logic             close_none;
    logic             walk_last;
    logic             walk_open;
  } dp_stat_t;

endpackage
`default_nettype wire

[src/ils_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_dpath: datapath of the indexed list store
// Element memory, length register, shift walker and result registers.
// ----------------------------------------------------------------------------
module ils_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ils_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  ils_pkg::dp_ctrl_t               ctrl_i,
  output ils_pkg::dp_stat_t               stat_o,
  output logic [ils_pkg::OUT_TDATA_W-1:0] m_tdata_o
);
  import ils_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = LW + INDEX_W;

  logic [DATA_W-1:0]      mem [CAPACITY];

  logic [CMD_W-1:0]       in_cmd;
  logic [INDEX_W-1:0]     in_idx;
  logic [DATA_W-1:0]      in_val;
  logic [AW-1:0]          in_pos;

  logic [CMD_W-1:0]       cmd_q;
  logic [INDEX_W-1:0]     idx_q;
  logic [DATA_W-1:0]      val_q;
  logic [AW-1:0]          pos_q;
  logic [LW-1:0]          len_q, len_d;
  logic [AW-1:0]          ptr_q;
  logic [AW-1:0]          wr_addr_q;
  logic                   pend_q;
  logic                   dir_open_q;
  logic [DATA_W-1:0]      rdata_q;
  logic [DATA_W-1:0]      res_rd_q;
  status_e                res_status_q;
  logic [OUT_TDATA_W-1:0] out_q;

  logic [EW-1:0]          len_ext, idx_ext, pos_ext, ptr_ext;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [DATA_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;

  assign in_cmd = s_tdata_i[CMD_W-1:0];
  assign in_idx = s_tdata_i[CMD_W +: INDEX_W];
  assign in_val = s_tdata_i[CMD_W + INDEX_W +: DATA_W];
  assign in_pos = (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_POP_FRONT) ? '0 : AW'(in_idx);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= in_cmd;
      idx_q <= in_idx;
      val_q <= in_val;
      pos_q <= in_pos;
    end
  end

  // Flags for the controller.
  assign len_ext = EW'(len_q);
  assign idx_ext = EW'(idx_q);
  assign pos_ext = EW'(pos_q);
  assign ptr_ext = EW'(ptr_q);

  assign stat_o.cmd        = cmd_q;
  assign stat_o.full       = (len_ext == EW'(CAPACITY));
  assign stat_o.empty      = (len_q == '0);
  assign stat_o.idx_ok     = (idx_ext < len_ext);
  assign stat_o.open_none  = (pos_ext == len_ext);
  assign stat_o.close_none = ((pos_ext + EW'(1)) == len_ext);
  assign stat_o.walk_last  = dir_open_q ? (ptr_q == pos_q) : ((ptr_ext + EW'(1)) == len_ext);
  assign stat_o.walk_open  = dir_open_q;

  // Length register.
  always_comb begin
    case (ctrl_i.len_op)
      LEN_INC: len_d = len_q + LW'(1);
      LEN_DEC: len_d = len_q - LW'(1);
      LEN_CLR: len_d = '0;
      default: len_d = len_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pend_q     <= 1'b0;
      dir_open_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (ctrl_i.walk_init) begin
        pend_q     <= 1'b0;
        dir_open_q <= ctrl_i.walk_open;
      end else if (ctrl_i.walk_step) begin
        pend_q <= 1'b1;
      end
    end
  end

  // Walk pointer: an opening walk runs down from the tail, a closing walk up.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.walk_init) begin
      ptr_q <= ctrl_i.walk_open ? AW'(len_q - LW'(1)) : pos_q + AW'(1);
    end else if (ctrl_i.walk_step) begin
      ptr_q     <= dir_open_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
      wr_addr_q <= dir_open_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
    end
  end

  // Single write port and single registered read port.
  assign mem_we    = (pend_q && (ctrl_i.walk_step || ctrl_i.drain)) || ctrl_i.wr_value;
  assign mem_waddr = ctrl_i.wr_value ? (ctrl_i.wr_tail ? AW'(len_q) : pos_q) : wr_addr_q;
  assign mem_wdata = ctrl_i.wr_value ? val_q : rdata_q;
  assign mem_re    = ctrl_i.walk_step || ctrl_i.fetch;
  assign mem_raddr = ctrl_i.fetch ? pos_q : ptr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Result and output registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      res_status_q <= ctrl_i.res_status;
      case (ctrl_i.res_rd)
        RD_NEG1: res_rd_q <= '1;
        RD_MEM:  res_rd_q <= rdata_q;
        default: res_rd_q <= '0;
      endcase
    end
    if (ctrl_i.out_load) begin
      out_q <= {res_status_q, (len_q == '0), COUNT_W'(len_q), res_rd_q};
    end
  end

  assign m_tdata_o = out_q;

endmodule
`default_nettype wire

[src/ils_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ctrl: controller of the indexed list store
// Sequences each command through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  ils_pkg::dp_stat_t stat_i,
  output ils_pkg::dp_ctrl_t ctrl_o
);
  import ils_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   s_fire;

  assign s_tready_o = (state_q == S_IDLE);
  assign s_fire     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (stat_i.cmd)
          CMD_PUSH_FRONT: if (!stat_i.full && !stat_i.open_none) state_d = S_WALK;
          CMD_INSERT:     if (stat_i.idx_ok && !stat_i.full) state_d = S_WALK;
          CMD_POP_FRONT:  if (!stat_i.empty && !stat_i.close_none) state_d = S_WALK;
          CMD_REMOVE:     if (stat_i.idx_ok && !stat_i.close_none) state_d = S_WALK;
          CMD_READ:       if (stat_i.idx_ok) state_d = S_FINISH;
          default:        state_d = S_DONE;
        endcase
      end
      S_WALK: begin
        if (stat_i.walk_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = stat_i.walk_open ? S_WRITE : S_DONE;
      end
      S_WRITE:  state_d = S_DONE;
      S_FINISH: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || m_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl_o            = '0;
    ctrl_o.len_op     = LEN_KEEP;
    ctrl_o.res_status = STAT_OK;
    ctrl_o.res_rd     = RD_ZERO;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.capture = s_fire;
      end
      S_EXEC: begin
        ctrl_o.res_load = 1'b1;
        unique case (stat_i.cmd)
          CMD_PUSH_BACK: begin
            if (stat_i.full) begin
              ctrl_o.res_status = STAT_FULL;
            end else begin
              ctrl_o.wr_value = 1'b1;
              ctrl_o.wr_tail  = 1'b1;
              ctrl_o.len_op   = LEN_INC;
            end
          end
          CMD_PUSH_FRONT: begin
            if (stat_i.full) begin
              ctrl_o.res_status = STAT_FULL;
            end else if (stat_i.open_none) begin
              ctrl_o.wr_value = 1'b1;
              ctrl_o.len_op   = LEN_INC;
            end else begin
              ctrl_o.res_load  = 1'b0;
              ctrl_o.walk_init = 1'b1;
              ctrl_o.walk_open = 1'b1;
            end
          end
          CMD_POP_FRONT: begin
            if (stat_i.empty) begin
              ctrl_o.res_status = STAT_EMPTY;
            end else if (stat_i.close_none) begin
              ctrl_o.len_op = LEN_DEC;
            end else begin
              ctrl_o.res_load  = 1'b0;
              ctrl_o.walk_init = 1'b1;
            end
          end
          CMD_POP_BACK: begin
            if (stat_i.empty) begin
              ctrl_o.res_status = STAT_EMPTY;
            end else begin
              ctrl_o.len_op = LEN_DEC;
            end
          end
          CMD_REMOVE: begin
            if (!stat_i.idx_ok) begin
              ctrl_o.res_status = STAT_INDEX;
            end else if (stat_i.close_none) begin
              ctrl_o.len_op = LEN_DEC;
            end else begin
              ctrl_o.res_load  = 1'b0;
              ctrl_o.walk_init = 1'b1;
            end
          end
          CMD_INSERT: begin
            if (!stat_i.idx_ok) begin
              ctrl_o.res_status = STAT_INDEX;
            end else if (stat_i.full) begin
              ctrl_o.res_status = STAT_FULL;
            end else begin
              ctrl_o.res_load  = 1'b0;
              ctrl_o.walk_init = 1'b1;
              ctrl_o.walk_open = 1'b1;
            end
          end
          CMD_SET: begin
            if (!stat_i.idx_ok) begin
              ctrl_o.res_status = STAT_INDEX;
            end else begin
              ctrl_o.wr_value = 1'b1;
            end
          end
          CMD_READ: begin
            if (!stat_i.idx_ok) begin
              ctrl_o.res_status = STAT_INDEX;
              ctrl_o.res_rd     = RD_NEG1;
            end else begin
              ctrl_o.res_load = 1'b0;
              ctrl_o.fetch    = 1'b1;
            end
          end
          CMD_CLEAR: begin
            ctrl_o.len_op = LEN_CLR;
          end
          default: begin
            ctrl_o.res_status = STAT_OK;
          end
        endcase
      end
      S_WALK: begin
        ctrl_o.walk_step = 1'b1;
      end
      S_DRAIN: begin
        ctrl_o.drain = 1'b1;
        if (!stat_i.walk_open) begin
          ctrl_o.len_op   = LEN_DEC;
          ctrl_o.res_load = 1'b1;
        end
      end
      S_WRITE: begin
        ctrl_o.wr_value = 1'b1;
        ctrl_o.len_op   = LEN_INC;
        ctrl_o.res_load = 1'b1;
      end
      S_FINISH: begin
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_rd   = RD_MEM;
      end
      S_DONE: begin
        ctrl_o.out_load = !out_valid_q || m_tready_i;
      end
      default: begin
        ctrl_o.capture = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[src/indexed_list_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store: bounded ordered list of signed 32-bit words
// Push and pop at both ends, remove, insert, set and read by index, clear.
// ----------------------------------------------------------------------------
// Each command beat yields exactly one result beat carrying the read data,
// the element count after the command (kept to 5 bits), an empty flag and
// a status code (ok, bad index, full, empty on pop). The elements live in a
// memory with one write port and one registered read port, so a push at the
// front, an insert, a pop from the front and a remove shift the affected
// elements one per cycle. A front push or an insert first moves the elements
// from the tail down to the position up by one and then writes the value; a
// front pop or a remove moves the elements above the position down by one.
// When nothing has to move they finish like all other commands, and a good
// read adds a memory fetch. The result register is loaded before the output
// register, and the input opens again once the output register is loaded. A
// new command is taken while the previous result still waits in the output
// register; the block stalls only if a second result is ready before the
// first one is taken. Memory entries hold no reset value, and nothing sweeps
// them after reset; only entries below the count are read.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command beats: cmd [3:0], index [8:4], value [40:9], zero [47:41].
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ils_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result beats: read_data [31:0], count [36:32], is_empty [37],
  // status [39:38].
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ils_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ils_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // The controller sequences each command; all storage sits in the datapath.
  ils_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ils_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .m_tdata_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

[src/ils_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed list store
// Watches the stream ports and checks handshake and result consistency.
// ----------------------------------------------------------------------------
module ils_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ils_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ils_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Commands are worked one at a time, so the input closes after a beat.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted a beat while busy");

  // A full status is only reported with the store at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[39:38] == STAT_FULL)
      |-> m_axis_tdata[36:32] == COUNT_W'(CAPACITY))
    else $error("full status with a count below capacity");

  // A pop on an empty store reports empty and no data.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[39:38] == STAT_EMPTY)
      |-> m_axis_tdata[37] && (m_axis_tdata[31:0] == '0))
    else $error("empty status without an empty store");

  // The empty flag agrees with the count when the count cannot wrap.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (CAPACITY < 32)
      |-> m_axis_tdata[37] == (m_axis_tdata[36:32] == '0))
    else $error("empty flag disagrees with count");

endmodule

bind indexed_list_store ils_checker #(
  .CAPACITY (CAPACITY)
) u_ils_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
